### hw/rtl/cgd_pkg.sv
`default_nettype none
package cgd_pkg;
	localparam logic [1:0] VAR_FR     = 2'd0;
	localparam logic [1:0] VAR_PR     = 2'd1;
	localparam logic [1:0] VAR_PRPLUS = 2'd2;
	localparam logic [1:0] VAR_HYBRID = 2'd3;
	localparam logic [0:0] CFG_VARIANT   = 1'b0;
	localparam logic [0:0] CFG_THRESHOLD = 1'b1;
	localparam logic [31:0] THRESH_RESET = 32'd4295;

	typedef enum logic [3:0] {
		ST_LOAD, ST_PREP, ST_DIV_FR, ST_DIV_PR, ST_PASS1, ST_WAIT1, ST_DECIDE, ST_EMIT
	} cgd_state_t;

	// word handed from the front to the back through the queue
	typedef struct packed {
		logic [31:0] grad;
		logic [31:0] pgrad;
		logic [31:0] dir;
		logic        last;
	} cgd_word_t;

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else sat_add64 = s[63:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
		else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
		else sat32 = v[31:0];
	endfunction
endpackage
`default_nettype wire

### hw/rtl/conjugate_gradient_direction_unit.sv
// Conjugate gradient direction unit.
// in channel: one vector element a word (cur_grad, prev_grad, prev_dir, last_elem)
// on in_valid/in_ready. A four-word front queue takes elements one a cycle when not full.
// cfg port: cfg_we, cfg_index, cfg_data; write only while idle.
// out channel: dir_elem with last_out, restarted, divide_fault on out_valid/out_ready;
// one word per loaded element, sent after the final element of the vector.
// After the last element leaves the queue the unit prepares, then runs the bit-serial
// divider (one division for most rules, two for the hybrid rule, none when the
// previous-gradient sum is zero), then the direction pass and a decide step, then
// emission, one word a cycle when the receiver is ready.
// Reset clears sums, counts and the queue; the stores need no clearing.
// A stalled receiver holds the current word; the front keeps filling the queue.
`default_nettype none
module conjugate_gradient_direction_unit
	import cgd_pkg::*;
#(
	parameter int VEC_LEN_MAX = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] cur_grad,
	input  wire logic [31:0] prev_grad,
	input  wire logic [31:0] prev_dir,
	input  wire logic        last_elem,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      dir_elem,
	output logic             last_out,
	output logic             restarted,
	output logic             divide_fault
);
	logic [1:0]  variant_q;
	logic [31:0] thresh_q;
	logic        full, empty, pop;
	cgd_word_t   w_in, w_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= VAR_FR;
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VARIANT:   variant_q <= cfg_data[1:0];
				CFG_THRESHOLD: thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_in = '{grad: cur_grad, pgrad: prev_grad, dir: prev_dir, last: last_elem};
	assign in_ready = !full;

	cgd_queue u_q (
		.clk(clk), .arst_n(arst_n), .push(in_valid), .push_word(w_in),
		.full(full), .empty(empty), .pop(pop), .pop_word(w_out)
	);

	cgd_back #(.VEC_LEN_MAX(VEC_LEN_MAX)) u_back (
		.clk(clk), .arst_n(arst_n), .variant(variant_q), .thresh(thresh_q),
		.q_empty(empty), .q_word(w_out), .q_pop(pop),
		.dir_elem(dir_elem), .last_out(last_out), .restarted(restarted),
		.divide_fault(divide_fault), .out_valid(out_valid), .out_ready(out_ready)
	);
endmodule
`default_nettype wire

### hw/rtl/cgd_queue.sv
`default_nettype none
module cgd_queue
	import cgd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  cgd_word_t      push_word,
	output logic           full,
	output logic           empty,
	input  wire logic      pop,
	output cgd_word_t      pop_word
);
	cgd_word_t  mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign full = cnt_q == 3'd4;
	assign empty = cnt_q == 3'd0;
	assign pop_word = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + 2'd1;
			if (pop && !empty) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'((push && !full) ? 1 : 0) - 3'((pop && !empty) ? 1 : 0);
		end
	end
endmodule
`default_nettype wire

### hw/rtl/cgd_divider.sv
`default_nettype none
module cgd_divider
	import cgd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [63:0] num,
	input  wire logic [63:0]        den,
	output logic                    done,
	output logic signed [31:0]      quo
);
	// restoring division, one quotient bit a cycle, 80 bits (64 integer + 16 fraction)
	logic [63:0] rem_q, mag_q;
	logic [79:0] q_q;
	logic [6:0]  cnt_q;
	logic        busy_q, neg_q;
	logic [64:0] trial;
	logic [31:0] mag;

	assign trial = {rem_q, (cnt_q < 7'd64) ? mag_q[63] : 1'b0};
	assign mag = (q_q[79:16] >= 64'd32768) ? 32'h7fffffff : {1'b0, q_q[30:0]};
	assign quo = neg_q ? -mag : mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
			neg_q <= 1'b0;
			rem_q <= '0;
			mag_q <= '0;
			q_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				neg_q <= num[63];
				mag_q <= num[63] ? 64'(-num) : num;
				rem_q <= '0;
				q_q <= '0;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (trial >= {1'b0, den}) begin
					rem_q <= 64'(trial - {1'b0, den});
					q_q <= {q_q[78:0], 1'b1};
				end else begin
					rem_q <= trial[63:0];
					q_q <= {q_q[78:0], 1'b0};
				end
				mag_q <= {mag_q[62:0], 1'b0};
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd79) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

### hw/rtl/cgd_back.sv
`default_nettype none
module cgd_back
	import cgd_pkg::*;
#(
	parameter int VEC_LEN_MAX = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [1:0]   variant,
	input  wire logic [31:0]  thresh,
	input  wire logic         q_empty,
	input  cgd_word_t         q_word,
	output logic              q_pop,
	output logic [31:0]       dir_elem,
	output logic              last_out,
	output logic              restarted,
	output logic              divide_fault,
	output logic              out_valid,
	input  wire logic         out_ready
);
	localparam int AW = $clog2(VEC_LEN_MAX);
	localparam int CW = $clog2(VEC_LEN_MAX + 1);

	logic [31:0] grad_mem [VEC_LEN_MAX];
	logic [31:0] odir_mem [VEC_LEN_MAX];
	logic [31:0] ndir_mem [VEC_LEN_MAX];

	cgd_state_t state_q, state_d;
	logic signed [63:0] gg_q, pp_q, gp_q, gd_q;
	logic [CW-1:0] n_q, idx_q;
	logic signed [31:0] beta_q, fr_q;
	logic fault_q, restart_q;

	// pass 1 pipeline
	logic [31:0] g_s1, dd_s1, g_s2, g_s3;
	logic        v_s1, v_s2, v_s3, v_s4;
	logic [AW-1:0] a_s1, a_s2, a_s3;
	logic signed [63:0] bd_s2, ge_s4;
	logic signed [31:0] e_s3;
	logic [31:0] rg_s1, rn_s1;

	logic signed [63:0] prnum, den_num;
	logic div_start, div_done;
	logic signed [31:0] div_quo;
	logic signed [63:0] fl;
	logic [63:0] agd;
	logic do_load, issue, emit_adv, q_last;
	logic [CW-1:0] n_next;

	assign prnum = sat_add64(gg_q, (gp_q == {1'b1, 63'd0}) ? {1'b0, {63{1'b1}}} : -gp_q);
	assign den_num = (state_q == ST_PREP && variant != VAR_PR && variant != VAR_PRPLUS) ?
		gg_q : prnum;

	cgd_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(den_num), .den(pp_q),
		.done(div_done), .quo(div_quo)
	);

	assign do_load = state_q == ST_LOAD && !q_empty;
	assign q_pop = do_load;
	assign n_next = n_q + CW'(1);
	assign q_last = q_word.last || n_next == CW'(VEC_LEN_MAX);
	assign issue = state_q == ST_PASS1;
	assign emit_adv = out_valid && out_ready;
	assign agd = gd_q[63] ? 64'(-gd_q) : gd_q;

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		case (state_q)
			ST_LOAD:   if (do_load && q_last) state_d = ST_PREP;
			ST_PREP: begin
				if (pp_q <= 0) state_d = ST_PASS1;
				else begin
					div_start = 1'b1;
					state_d = (variant == VAR_HYBRID) ? ST_DIV_FR : ST_DIV_PR;
				end
			end
			ST_DIV_FR: if (div_done) begin
				div_start = 1'b1;
				state_d = ST_DIV_PR;
			end
			ST_DIV_PR: if (div_done) state_d = ST_PASS1;
			ST_PASS1:  if (idx_q == n_q - CW'(1)) state_d = ST_WAIT1;
			ST_WAIT1:  if (!v_s1 && !v_s2 && !v_s3 && !v_s4) state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_EMIT;
			ST_EMIT:   if (emit_adv && last_out) state_d = ST_LOAD;
			default:   state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	// vector stores
	always_ff @(posedge clk) begin
		if (do_load) begin
			grad_mem[n_q[AW-1:0]] <= q_word.grad;
			odir_mem[n_q[AW-1:0]] <= q_word.dir;
		end
		if (v_s3) ndir_mem[a_s3] <= e_s3;
		g_s1 <= grad_mem[idx_q[AW-1:0]];
		dd_s1 <= odir_mem[idx_q[AW-1:0]];
		rg_s1 <= grad_mem[idx_q[AW-1:0]];
		rn_s1 <= ndir_mem[idx_q[AW-1:0]];
	end

	assign fl = bd_s2 >>> 16;

	always_ff @(posedge clk) begin
		a_s1 <= idx_q[AW-1:0];
		a_s2 <= a_s1;
		g_s2 <= g_s1;
		bd_s2 <= beta_q * $signed(dd_s1);
		a_s3 <= a_s2;
		g_s3 <= g_s2;
		e_s3 <= sat32(fl - 64'($signed(g_s2)));
		ge_s4 <= $signed(g_s3) * e_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gg_q <= '0; pp_q <= '0; gp_q <= '0; gd_q <= '0;
			n_q <= '0; idx_q <= '0; beta_q <= '0; fr_q <= '0;
			fault_q <= 1'b0; restart_q <= 1'b0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s4) gd_q <= sat_add64(gd_q, ge_s4);
			case (state_q)
				ST_LOAD: if (do_load) begin
					gg_q <= sat_add64(gg_q, $signed(q_word.grad) * $signed(q_word.grad));
					pp_q <= sat_add64(pp_q, $signed(q_word.pgrad) * $signed(q_word.pgrad));
					gp_q <= sat_add64(gp_q, $signed(q_word.grad) * $signed(q_word.pgrad));
					n_q <= n_next;
				end
				ST_PREP: begin
					beta_q <= '0;
					fault_q <= pp_q <= 0;
					idx_q <= '0;
					gd_q <= '0;
				end
				ST_DIV_FR: if (div_done) fr_q <= div_quo;
				ST_DIV_PR: if (div_done) begin
					case (variant)
						VAR_PRPLUS: beta_q <= div_quo[31] ? '0 : div_quo;
						VAR_HYBRID: begin
							if (div_quo < -fr_q) beta_q <= -fr_q;
							else if (div_quo > fr_q) beta_q <= fr_q;
							else beta_q <= div_quo;
						end
						default: beta_q <= div_quo;
					endcase
				end
				ST_PASS1: idx_q <= idx_q + CW'(1);
				ST_WAIT1: idx_q <= '0;
				ST_DECIDE: begin
					restart_q <= agd < {32'd0, thresh};
					out_valid <= 1'b1;
					idx_q <= CW'(1);
				end
				ST_EMIT: if (emit_adv) begin
					if (last_out) begin
						out_valid <= 1'b0;
						gg_q <= '0; pp_q <= '0; gp_q <= '0; n_q <= '0;
					end
					idx_q <= idx_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	// emit pass: registered reads, hold while stalled
	logic [CW-1:0] e_idx_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) e_idx_q <= '0;
		else if (state_q == ST_DECIDE) e_idx_q <= '0;
		else if (emit_adv) e_idx_q <= e_idx_q + CW'(1);
	end

	logic [31:0] hold_g_q, hold_n_q;
	logic        fresh_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fresh_q <= 1'b0;
		else fresh_q <= state_q == ST_DECIDE || emit_adv;
	end
	always_ff @(posedge clk) begin
		if (fresh_q) begin
			hold_g_q <= rg_s1;
			hold_n_q <= rn_s1;
		end
	end

	logic [31:0] cur_g, cur_n;
	assign cur_g = fresh_q ? rg_s1 : hold_g_q;
	assign cur_n = fresh_q ? rn_s1 : hold_n_q;
	// the read address is idx_q, one ahead of e_idx_q
	assign dir_elem = restart_q ? sat32(-64'($signed(cur_g))) : cur_n;
	assign last_out = e_idx_q == n_q - CW'(1);
	assign restarted = restart_q;
	assign divide_fault = fault_q;
endmodule
`default_nettype wire

### hw/rtl/cgd_checker.sv
`default_nettype none
module cgd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] dir_elem,
	input wire logic        last_out,
	input wire logic        restarted,
	input wire logic        divide_fault
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dir_elem))
		else $error("output word changed under stall");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_out |=> $stable(restarted) && $stable(divide_fault))
		else $error("flags changed inside a vector");
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_out |=> !out_valid)
		else $error("output continued past last word");
endmodule

bind conjugate_gradient_direction_unit cgd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.dir_elem(dir_elem), .last_out(last_out), .restarted(restarted),
	.divide_fault(divide_fault)
);
`default_nettype wire
